// ===== rtl/ddf_pkg.sv =====
// Shared types and constants for the display digit formatter.
// No dependencies.
package ddf_pkg;

    localparam int unsigned VALUE_W = 14;
    localparam int unsigned GLYPH_W = 4;

    localparam logic [GLYPH_W-1:0] GLYPH_POINT = 4'd10;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 4'd14;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = 14'd9999;

    // floor(x * 6554 / 65536) == floor(x / 10) for x <= 9999
    localparam logic [12:0] RECIP_10 = 13'd6554;
    localparam int unsigned RECIP_SHIFT = 16;

    typedef enum logic {
        OP_INTEGER = 1'b0,
        OP_DECIMAL = 1'b1
    } op_t;

    // Item as it moves down the digit pipeline. digs collects remainders,
    // newest at the top: after three stages [11:8]=hundreds, [7:4]=tens,
    // [3:0]=units, and rest holds the thousands digit.
    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] rest;
        logic [11:0]        digs;
    } item_t;

endpackage

// ===== rtl/display_digit_formatter_top.sv =====
// Display digit formatter: value and mode in, four glyph codes out.
// Registers in order: saturate register, three divide-by-10 stages, glyph register.
// Throughput one transfer per cycle while m_ready is high; a full stage holds while its successor cannot accept.
// Synchronous active-low reset clears the stage valid bits only.
// Depends on ddf_pkg, ddf_div10_stage, ddf_glyph_stage.
module display_digit_formatter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [13:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_digit_0,
    output logic [3:0]  m_digit_1,
    output logic [3:0]  m_digit_2,
    output logic [3:0]  m_digit_3
);

    logic           valid_reg;
    ddf_pkg::item_t item_reg;
    ddf_pkg::item_t item_next;

    logic           v1, v2, v3;
    logic           r1, r2, r3, r4;
    ddf_pkg::item_t i1, i2, i3;

    always_comb begin
        item_next.op   = ddf_pkg::op_t'(s_op);
        item_next.rest = (s_value > ddf_pkg::VALUE_MAX) ? ddf_pkg::VALUE_MAX : s_value;
        item_next.digs = 12'd0;
    end

    assign s_ready = !valid_reg || r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

    ddf_div10_stage u_units (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_reg),
        .in_ready  (r1),
        .in_item   (item_reg),
        .out_valid (v1),
        .out_ready (r2),
        .out_item  (i1)
    );

    ddf_div10_stage u_tens (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r2),
        .in_item   (i1),
        .out_valid (v2),
        .out_ready (r3),
        .out_item  (i2)
    );

    ddf_div10_stage u_hundreds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r3),
        .in_item   (i2),
        .out_valid (v3),
        .out_ready (r4),
        .out_item  (i3)
    );

    ddf_glyph_stage u_glyph (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r4),
        .in_item   (i3),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .digit_0   (m_digit_0),
        .digit_1   (m_digit_1),
        .digit_2   (m_digit_2),
        .digit_3   (m_digit_3)
    );

endmodule

// ===== rtl/ddf_div10_stage.sv =====
// One pipeline stage: peels the lowest decimal digit off the running value.
// Depends on ddf_pkg.
module ddf_div10_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ddf_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output ddf_pkg::item_t  out_item
);

    logic           valid_reg;
    ddf_pkg::item_t item_reg;
    ddf_pkg::item_t item_next;
    logic [26:0]    prod;
    logic [10:0]    quot;
    logic [13:0]    quot_x10;
    logic [13:0]    rem;

    always_comb begin
        prod      = {13'd0, in_item.rest} * {14'd0, ddf_pkg::RECIP_10};
        quot      = prod[26:ddf_pkg::RECIP_SHIFT];
        quot_x10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem       = in_item.rest - quot_x10;
        item_next.op   = in_item.op;
        item_next.rest = {3'b000, quot};
        item_next.digs = {rem[3:0], in_item.digs[11:4]};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/ddf_glyph_stage.sv =====
// Output stage: maps the four decimal digits to glyph codes per mode.
// Depends on ddf_pkg.
module ddf_glyph_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ddf_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [3:0]     digit_0,
    output logic [3:0]     digit_1,
    output logic [3:0]     digit_2,
    output logic [3:0]     digit_3
);

    logic       valid_reg;
    logic [3:0] g0_reg, g1_reg, g2_reg, g3_reg;
    logic [3:0] g0_next, g1_next, g2_next, g3_next;
    logic [3:0] d0, d1, d2, d3;
    logic       blank0, blank1, blank2;

    always_comb begin
        d0 = in_item.rest[3:0];
        d1 = in_item.digs[11:8];
        d2 = in_item.digs[7:4];
        d3 = in_item.digs[3:0];
        blank0 = (d0 == 4'd0);
        blank1 = blank0 && (d1 == 4'd0);
        blank2 = blank1 && (d2 == 4'd0);
        unique case (in_item.op)
            ddf_pkg::OP_INTEGER: begin
                g0_next = blank0 ? ddf_pkg::GLYPH_BLANK : d0;
                g1_next = blank1 ? ddf_pkg::GLYPH_BLANK : d1;
                g2_next = blank2 ? ddf_pkg::GLYPH_BLANK : d2;
                g3_next = d3;
            end
            ddf_pkg::OP_DECIMAL: begin
                // thousands digit zero means under 10.00: d.dd, else dd.d
                if (blank0) begin
                    g0_next = d1;
                    g1_next = ddf_pkg::GLYPH_POINT;
                    g2_next = d2;
                    g3_next = d3;
                end else begin
                    g0_next = d0;
                    g1_next = d1;
                    g2_next = ddf_pkg::GLYPH_POINT;
                    g3_next = d2;
                end
            end
            default: begin
                g0_next = d0;
                g1_next = d1;
                g2_next = d2;
                g3_next = d3;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign digit_0   = g0_reg;
    assign digit_1   = g1_reg;
    assign digit_2   = g2_reg;
    assign digit_3   = g3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            g0_reg <= g0_next;
            g1_reg <= g1_next;
            g2_reg <= g2_next;
            g3_reg <= g3_next;
        end
    end

endmodule
